>>> rtl/atct_pkg.sv
// ----------------------------------------------------------------------------
// atct_pkg
// Shared constants, register codes and state type for the tempo tracker.
// ----------------------------------------------------------------------------
package atct_pkg;

  // Envelope ring geometry and envelope sample rate
  localparam int RING_LEN = 400;
  localparam int ENVELOPE_RATE = 100;
  localparam int AW = $clog2(RING_LEN);
  localparam int LW = (AW > 9) ? AW : 9;

  // Datapath widths
  localparam int SCORE_W = 32;
  localparam int ACC_W = 31 + AW;
  localparam int TOT_W = 31 + AW;
  localparam int NUM_W = 48;
  localparam int DEN_W = TOT_W;
  localparam int TEMPO_NUM = 960 * ENVELOPE_RATE;

  // Configuration port
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LPF_ALPHA = 3'd0,
    REG_DECIM     = 3'd1,
    REG_MIN_LAG   = 3'd2,
    REG_MAX_LAG   = 3'd3,
    REG_CONF_TH   = 3'd4
  } atct_reg_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LVL,
    S_AINIT,
    S_LSTART,
    S_MAC,
    S_LDIV,
    S_LWAIT,
    S_SCORE,
    S_PRD,
    S_PCHK,
    S_CMUL,
    S_CDIV,
    S_CWAIT,
    S_TDIV,
    S_TWAIT,
    S_DONE
  } atct_state_t;

endpackage

>>> rtl/atct_in_if.sv
// ----------------------------------------------------------------------------
// atct_in_if
// Audio sample channel: valid/ready handshake with one signed sample per beat.
// ----------------------------------------------------------------------------
interface atct_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] audio_sample;

  modport source (output valid, output audio_sample, input ready);
  modport sink (input valid, input audio_sample, output ready);
endinterface

>>> rtl/atct_out_if.sv
// ----------------------------------------------------------------------------
// atct_out_if
// Tempo result channel: valid/ready handshake with one estimate per beat.
// ----------------------------------------------------------------------------
interface atct_out_if;
  logic        valid;
  logic        ready;
  logic [8:0]  beat_lag;
  logic [15:0] tempo_q4;
  logic [15:0] confidence_q8;
  logic        tempo_valid;

  modport source (output valid, output beat_lag, output tempo_q4,
                  output confidence_q8, output tempo_valid, input ready);
  modport sink (input valid, input beat_lag, input tempo_q4,
                input confidence_q8, input tempo_valid, output ready);
endinterface

>>> rtl/atct_div.sv
// ----------------------------------------------------------------------------
// atct_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module atct_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       go,
  input  logic [atct_pkg::NUM_W-1:0] num,
  input  logic [atct_pkg::DEN_W-1:0] den,
  output logic                       done,
  output logic [atct_pkg::NUM_W-1:0] quo
);

  localparam int CW = $clog2(atct_pkg::NUM_W + 1);

  logic [atct_pkg::DEN_W:0]   rem_r;
  logic [atct_pkg::NUM_W-1:0] quo_r;
  logic [atct_pkg::DEN_W-1:0] den_r;
  logic [CW-1:0]              cnt_r;
  logic                       busy_r;
  logic                       done_r;
  logic [atct_pkg::DEN_W+1:0] trial;

  // Shift in the next dividend bit and try a subtract
  assign trial = {rem_r, quo_r[atct_pkg::NUM_W-1]} - {2'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(atct_pkg::NUM_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Hold operands and step the remainder
  always_ff @(posedge clk) begin
    if (go) begin
      rem_r <= '0;
      quo_r <= num;
      den_r <= den;
    end else if (busy_r) begin
      if (!trial[atct_pkg::DEN_W+1]) begin
        rem_r <= trial[atct_pkg::DEN_W:0];
        quo_r <= {quo_r[atct_pkg::NUM_W-2:0], 1'b1};
      end else begin
        rem_r <= {rem_r[atct_pkg::DEN_W-1:0], quo_r[atct_pkg::NUM_W-1]};
        quo_r <= {quo_r[atct_pkg::NUM_W-2:0], 1'b0};
      end
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

>>> rtl/autocorrelation_tempo_tracker_top.sv
// ----------------------------------------------------------------------------
// autocorrelation_tempo_tracker_top
// Envelope follower, decimating peak ring and autocorrelation tempo search.
// ----------------------------------------------------------------------------
// Flow: outside a period end each sample passes S_IDLE, S_LVL and S_DONE. At a
//   period end after the ring has wrapped, the search runs the ring MAC for
//   each lag, then the pick scan over the lags, then the divides.
// Flow control: one sample at a time, taken in S_IDLE; S_DONE stalls on ready.
//   The ring MAC (one product per cycle) and shared divider set analysis time.
// Reset: synchronous active-low; control, registers and held result clear,
//   memories are not cleared (the ring is full before it is ever read).
module autocorrelation_tempo_tracker_top (
  input  logic                                 clk,
  input  logic                                 rst_n,
  atct_in_if.sink                              in_bus,
  atct_out_if.source                           out_bus,
  input  logic                                 cfg_we,
  input  logic [atct_pkg::CFG_IDX_W-1:0]       cfg_idx,
  input  logic [atct_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int AW = atct_pkg::AW;
  localparam int LW = atct_pkg::LW;
  localparam int SW = atct_pkg::SCORE_W;
  localparam int RING_LEN_C = atct_pkg::RING_LEN;

  atct_pkg::atct_state_t state_r, state_nxt;

  // Configuration registers
  logic [15:0] alpha_r, decim_r, thresh_r;
  logic [8:0]  min_lag_r, max_lag_r;

  // Envelope state
  logic [31:0]        level_r;
  logic [15:0]        pcount_r, ppeak_r;
  logic [AW-1:0]      wp_r;
  logic               wrapped_r;
  logic signed [50:0] prod_r;

  // Analysis state
  logic [LW-1:0]             lo_r, hi_r, lag_r, pick_r, chosen_r;
  logic [AW-1:0]             pa_r, pb_r, n_r, i_r;
  logic                      v1_r, v2_r;
  logic [31:0]               mac_r;
  logic [atct_pkg::ACC_W-1:0] acc_r;
  logic [SW-1:0]             peak_r;
  logic [atct_pkg::TOT_W-1:0] total_r;
  logic [LW-1:0]             count_r;
  logic [atct_pkg::NUM_W-1:0] cnum_r;
  logic [15:0]               conf_r;

  // Held result and output register
  logic [8:0]  held_lag_r;
  logic [15:0] held_tempo_r, held_conf_r;
  logic        held_valid_r;
  logic        out_valid_r;
  logic [8:0]  out_lag_r;
  logic [15:0] out_tempo_r, out_conf_r;
  logic        out_tv_r;

  // Memories
  logic [15:0]   ring_mem [RING_LEN_C];
  logic [SW-1:0] score_mem [RING_LEN_C];
  logic [15:0]   ra_q, rb_q;
  logic [SW-1:0] sc_q;
  logic          ring_we;
  logic [15:0]   ring_wd;

  // Divider hookup
  logic                        div_go, div_done;
  logic [atct_pkg::NUM_W-1:0]  div_num, div_quo;
  logic [atct_pkg::DEN_W-1:0]  div_den;

  atct_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .go   (div_go),
    .num  (div_num),
    .den  (div_den),
    .done (div_done),
    .quo  (div_quo)
  );

  // Sample front end
  logic [16:0]        mag;
  logic signed [33:0] diff;
  logic signed [35:0] lvl_sum;
  logic [31:0]        lvl_new;
  logic [15:0]        env, pk, pcount_inc;
  logic               period_end;
  logic [AW-1:0]      wp_inc;
  logic [LW:0]        lo_w, hi_w, pb_sum;
  logic [35:0]        lhs10, rhs9;
  logic               hit;
  logic [LW:0]        tempo_num;

  always_comb begin
    mag = in_bus.audio_sample[15] ? (17'h10000 - {1'b0, in_bus.audio_sample})
                                  : {1'b0, in_bus.audio_sample};
    diff = $signed({1'b0, mag, 16'b0}) - $signed({2'b0, level_r});
    lvl_sum = $signed({4'b0, level_r}) + 36'(prod_r >>> 16);
    if (lvl_sum < 0) lvl_new = '0;
    else if (lvl_sum > 36'sh080000000) lvl_new = 32'h80000000;
    else lvl_new = lvl_sum[31:0];
    env = lvl_new[31:16];
    pk = (env > ppeak_r) ? env : ppeak_r;
    pcount_inc = pcount_r + 1'b1;
    period_end = (pcount_inc >= decim_r) || (pcount_inc == 16'd0);
    wp_inc = (wp_r == AW'(RING_LEN_C - 1)) ? '0 : wp_r + 1'b1;
    lo_w = (min_lag_r == 9'd0) ? (LW+1)'(1) : (LW+1)'(min_lag_r);
    hi_w = ((LW+1)'(max_lag_r) > (LW+1)'(RING_LEN_C - 1)) ? (LW+1)'(RING_LEN_C - 1)
                                                         : (LW+1)'(max_lag_r);
    pb_sum = (LW+1)'(wp_r) + (LW+1)'(lag_r);
    lhs10 = 36'(sc_q) * 36'd10;
    rhs9 = 36'(peak_r) * 36'd9;
    hit = lhs10 >= rhs9;
    tempo_num = '0;
    tempo_num[LW-1:0] = chosen_r >> 1;
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      atct_pkg::S_IDLE: if (in_bus.valid) state_nxt = atct_pkg::S_LVL;
      atct_pkg::S_LVL: begin
        if (period_end && (wrapped_r || wp_inc == '0)) state_nxt = atct_pkg::S_AINIT;
        else state_nxt = atct_pkg::S_DONE;
      end
      atct_pkg::S_AINIT:
        state_nxt = (lo_w > hi_w) ? atct_pkg::S_TDIV : atct_pkg::S_LSTART;
      atct_pkg::S_LSTART: state_nxt = atct_pkg::S_MAC;
      atct_pkg::S_MAC:
        if (i_r == n_r && !v1_r && !v2_r) state_nxt = atct_pkg::S_LDIV;
      atct_pkg::S_LDIV: state_nxt = atct_pkg::S_LWAIT;
      atct_pkg::S_LWAIT: if (div_done) state_nxt = atct_pkg::S_SCORE;
      atct_pkg::S_SCORE:
        state_nxt = (lag_r == hi_r) ? atct_pkg::S_PRD : atct_pkg::S_LSTART;
      atct_pkg::S_PRD: state_nxt = atct_pkg::S_PCHK;
      atct_pkg::S_PCHK:
        state_nxt = (hit || pick_r == hi_r) ? atct_pkg::S_CMUL : atct_pkg::S_PRD;
      atct_pkg::S_CMUL:
        state_nxt = (total_r == '0) ? atct_pkg::S_TDIV : atct_pkg::S_CDIV;
      atct_pkg::S_CDIV: state_nxt = atct_pkg::S_CWAIT;
      atct_pkg::S_CWAIT: if (div_done) state_nxt = atct_pkg::S_TDIV;
      atct_pkg::S_TDIV: state_nxt = atct_pkg::S_TWAIT;
      atct_pkg::S_TWAIT: if (div_done) state_nxt = atct_pkg::S_DONE;
      atct_pkg::S_DONE:
        if (!out_valid_r || out_bus.ready) state_nxt = atct_pkg::S_IDLE;
      default: state_nxt = atct_pkg::S_IDLE;
    endcase
  end

  // Handshake, ring write and divider operands
  always_comb begin
    in_bus.ready = (state_r == atct_pkg::S_IDLE);
    ring_we = (state_r == atct_pkg::S_LVL) && period_end;
    ring_wd = pk;
    div_go = 1'b0;
    div_num = '0;
    div_den = '0;
    case (state_r)
      atct_pkg::S_LDIV: begin
        div_go = 1'b1;
        div_num = atct_pkg::NUM_W'(acc_r);
        div_den = atct_pkg::DEN_W'(n_r);
      end
      atct_pkg::S_CDIV: begin
        div_go = 1'b1;
        div_num = cnum_r;
        div_den = total_r;
      end
      atct_pkg::S_TDIV: begin
        div_go = 1'b1;
        div_num = atct_pkg::NUM_W'(atct_pkg::TEMPO_NUM) + atct_pkg::NUM_W'(tempo_num);
        div_den = atct_pkg::DEN_W'(chosen_r);
      end
      default: ;
    endcase
  end

  // Ring and score memories, with registered reads
  always_ff @(posedge clk) begin
    if (ring_we) ring_mem[wp_r] <= ring_wd;
    ra_q <= ring_mem[pa_r];
    rb_q <= ring_mem[pb_r];
  end

  always_ff @(posedge clk) begin
    if (state_r == atct_pkg::S_SCORE) score_mem[lag_r[AW-1:0]] <= div_quo[SW-1:0];
    sc_q <= score_mem[pick_r[AW-1:0]];
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_r   <= 16'd393;
      decim_r   <= 16'd160;
      min_lag_r <= 9'd30;
      max_lag_r <= 9'd100;
      thresh_r  <= 16'd307;
    end else if (cfg_we) begin
      case (cfg_idx)
        atct_pkg::REG_LPF_ALPHA: alpha_r   <= cfg_data;
        atct_pkg::REG_DECIM:     decim_r   <= cfg_data;
        atct_pkg::REG_MIN_LAG:   min_lag_r <= cfg_data[8:0];
        atct_pkg::REG_MAX_LAG:   max_lag_r <= cfg_data[8:0];
        atct_pkg::REG_CONF_TH:   thresh_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Control state and held result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= atct_pkg::S_IDLE;
      level_r      <= '0;
      pcount_r     <= '0;
      ppeak_r      <= '0;
      wp_r         <= '0;
      wrapped_r    <= 1'b0;
      held_lag_r   <= '0;
      held_tempo_r <= '0;
      held_conf_r  <= '0;
      held_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
      v1_r         <= 1'b0;
      v2_r         <= 1'b0;
    end else begin
      state_r <= state_nxt;
      // Load a new output beat or drop the accepted one
      if (state_r == atct_pkg::S_DONE && (!out_valid_r || out_bus.ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_bus.ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        // Update the envelope and close the period
        atct_pkg::S_LVL: begin
          level_r <= lvl_new;
          if (period_end) begin
            pcount_r <= '0;
            ppeak_r  <= '0;
            wp_r     <= wp_inc;
            if (wp_inc == '0) wrapped_r <= 1'b1;
            if (!(wrapped_r || wp_inc == '0)) begin
              held_lag_r   <= '0;
              held_tempo_r <= '0;
              held_conf_r  <= '0;
              held_valid_r <= 1'b0;
            end
          end else begin
            pcount_r <= pcount_inc;
            ppeak_r  <= pk;
          end
        end
        atct_pkg::S_LSTART: begin
          v1_r <= 1'b0;
          v2_r <= 1'b0;
        end
        atct_pkg::S_MAC: begin
          v1_r <= (i_r != n_r);
          v2_r <= v1_r;
        end
        // Latch the result once the tempo divide lands
        atct_pkg::S_TWAIT: begin
          if (div_done) begin
            held_lag_r   <= chosen_r[8:0];
            held_tempo_r <= (div_quo > atct_pkg::NUM_W'(16'hFFFF)) ? 16'hFFFF
                                                                  : div_quo[15:0];
            held_conf_r  <= conf_r;
            held_valid_r <= conf_r >= thresh_r;
          end
        end
        default: ;
      endcase
    end
  end

  // Analysis datapath
  always_ff @(posedge clk) begin
    case (state_r)
      atct_pkg::S_IDLE: prod_r <= $signed({1'b0, alpha_r}) * diff;
      atct_pkg::S_AINIT: begin
        lo_r     <= lo_w[LW-1:0];
        hi_r     <= hi_w[LW-1:0];
        lag_r    <= lo_w[LW-1:0];
        chosen_r <= lo_w[LW-1:0];
        peak_r   <= '0;
        total_r  <= '0;
        count_r  <= '0;
        conf_r   <= '0;
      end
      atct_pkg::S_LSTART: begin
        i_r   <= '0;
        n_r   <= AW'((LW+1)'(RING_LEN_C) - (LW+1)'(lag_r));
        pa_r  <= wp_r;
        pb_r  <= (pb_sum >= (LW+1)'(RING_LEN_C)) ? AW'(pb_sum - (LW+1)'(RING_LEN_C))
                                                 : AW'(pb_sum);
        acc_r <= '0;
      end
      // Issue reads, multiply, accumulate
      atct_pkg::S_MAC: begin
        if (i_r != n_r) begin
          i_r  <= i_r + 1'b1;
          pa_r <= (pa_r == AW'(RING_LEN_C - 1)) ? '0 : pa_r + 1'b1;
          pb_r <= (pb_r == AW'(RING_LEN_C - 1)) ? '0 : pb_r + 1'b1;
        end
        if (v1_r) mac_r <= 32'(ra_q) * 32'(rb_q);
        if (v2_r) acc_r <= acc_r + atct_pkg::ACC_W'(mac_r);
      end
      atct_pkg::S_SCORE: begin
        total_r <= total_r + atct_pkg::TOT_W'(div_quo[SW-1:0]);
        if (div_quo[SW-1:0] > peak_r) peak_r <= div_quo[SW-1:0];
        count_r <= count_r + 1'b1;
        lag_r   <= lag_r + 1'b1;
        pick_r  <= lo_r;
      end
      atct_pkg::S_PCHK: begin
        if (hit) chosen_r <= pick_r;
        else if (pick_r != hi_r) pick_r <= pick_r + 1'b1;
      end
      atct_pkg::S_CMUL: cnum_r <= atct_pkg::NUM_W'({peak_r, 8'b0}) * atct_pkg::NUM_W'(count_r);
      atct_pkg::S_CWAIT: begin
        if (div_done) begin
          conf_r <= (div_quo > atct_pkg::NUM_W'(16'hFFFF)) ? 16'hFFFF : div_quo[15:0];
        end
      end
      // Hold the payload while a beat waits for ready
      atct_pkg::S_DONE: begin
        if (!out_valid_r || out_bus.ready) begin
          out_lag_r   <= held_lag_r;
          out_tempo_r <= held_tempo_r;
          out_conf_r  <= held_conf_r;
          out_tv_r    <= held_valid_r;
        end
      end
      default: ;
    endcase
  end

  assign out_bus.valid         = out_valid_r;
  assign out_bus.beat_lag      = out_lag_r;
  assign out_bus.tempo_q4      = out_tempo_r;
  assign out_bus.confidence_q8 = out_conf_r;
  assign out_bus.tempo_valid   = out_tv_r;

  // An accepted beat always enters the envelope update next
  a_accept_lvl: assert property (@(posedge clk) disable iff (!rst_n)
    in_bus.valid && in_bus.ready |=> state_r == atct_pkg::S_LVL)
    else $error("accepted sample did not reach envelope update");

  // Ring write pointer stays inside the ring
  a_wp_range: assert property (@(posedge clk) disable iff (!rst_n)
    wp_r < AW'(RING_LEN_C))
    else $error("ring write pointer out of range");

  // MAC read pointers stay inside the ring
  a_mac_ptr: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == atct_pkg::S_MAC |-> pa_r < AW'(RING_LEN_C) && pb_r < AW'(RING_LEN_C))
    else $error("autocorrelation read pointer out of range");

  // Lowpass level never exceeds full scale
  a_level: assert property (@(posedge clk) disable iff (!rst_n)
    level_r <= 32'h80000000)
    else $error("envelope level above full scale");

endmodule

>>> tb/autocorrelation_tempo_tracker_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// autocorrelation_tempo_tracker_top_tb
// Drives audio beats through the tempo tracker with random idles and output
// stalls. A local envelope/autocorrelation predictor computes the held tempo
// estimate after every beat, and each output beat is compared field by field.
// ----------------------------------------------------------------------------
module autocorrelation_tempo_tracker_top_tb;

  localparam int WATCHDOG_LIMIT = 400000;
  localparam int RING_LEN = atct_pkg::RING_LEN;
  localparam int TEMPO_NUM = atct_pkg::TEMPO_NUM;

  typedef struct packed {
    logic [8:0]  beat_lag;
    logic [15:0] tempo_q4;
    logic [15:0] confidence_q8;
    logic        tempo_valid;
  } estimate_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [atct_pkg::CFG_IDX_W-1:0] cfg_idx;
  logic [atct_pkg::CFG_DATA_W-1:0] cfg_data;

  atct_in_if  in_bus ();
  atct_out_if out_bus ();

  autocorrelation_tempo_tracker_top u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_bus   (in_bus.sink),
    .out_bus  (out_bus.source),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data)
  );

  // Predictor state and register copies
  logic [15:0] m_alpha, m_decim, m_thresh;
  logic [8:0]  m_min_lag, m_max_lag;
  logic [15:0] m_ring [RING_LEN];
  int          m_wpos;
  bit          m_wrapped;
  logic [31:0] m_level;
  logic [15:0] m_pcount, m_ppeak;
  estimate_t   m_held;

  estimate_t   pending_estimates[$];
  int          mismatch_count;
  int          quiet_cycles;
  bit          no_idle;
  int          stall_left;

  always #5 clk = ~clk;

  // Gap length: mostly zero or short, a few long
  function automatic int draw_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Autocorrelation search over the ring, oldest entry first
  function automatic void search_tempo();
    longint unsigned scores [RING_LEN];
    longint unsigned peak, total, acc, q, tempo;
    int lo, hi, lag, n, i, count, chosen;
    longint unsigned conf;
    lo = (m_min_lag < 1) ? 1 : int'(m_min_lag);
    hi = (m_max_lag > RING_LEN - 1) ? RING_LEN - 1 : int'(m_max_lag);
    peak = 0; total = 0; count = 0; chosen = lo; conf = 0;
    for (lag = lo; lag <= hi; lag++) begin
      n = RING_LEN - lag;
      acc = 0;
      for (i = 0; i < n; i++)
        acc += longint'(m_ring[(m_wpos + i) % RING_LEN]) *
               longint'(m_ring[(m_wpos + i + lag) % RING_LEN]);
      scores[lag] = acc / n;
      total += scores[lag];
      count++;
      if (count == 1 || scores[lag] > peak) peak = scores[lag];
    end
    for (lag = lo; lag <= hi; lag++) begin
      if (scores[lag] * 10 >= peak * 9) begin
        chosen = lag;
        break;
      end
    end
    if (count > 0 && total > 0) begin
      q = (peak * 256 * count) / total;
      conf = (q > 65535) ? 65535 : q;
    end
    tempo = (longint'(TEMPO_NUM) + chosen / 2) / chosen;
    m_held.beat_lag      = chosen[8:0];
    m_held.tempo_q4      = (tempo > 65535) ? 16'hFFFF : tempo[15:0];
    m_held.confidence_q8 = conf[15:0];
    m_held.tempo_valid   = (conf >= m_thresh);
  endfunction

  // Advance the envelope follower by one sample and return the held estimate
  function automatic estimate_t predict_estimate(logic [15:0] raw);
    logic [16:0] mag;
    longint diff, prod, delta, lvl;
    logic [15:0] env;
    mag = raw[15] ? (17'h10000 - {1'b0, raw}) : {1'b0, raw};
    diff = (longint'(mag) <<< 16) - longint'(m_level);
    prod = longint'(m_alpha) * diff;
    delta = (prod >= 0) ? (prod >>> 16) : -((-prod + 65535) >>> 16);
    lvl = longint'(m_level) + delta;
    if (lvl < 0) lvl = 0;
    if (lvl > 64'h8000_0000) lvl = 64'h8000_0000;
    m_level = lvl[31:0];
    env = m_level[31:16];
    if (env > m_ppeak) m_ppeak = env;
    m_pcount = m_pcount + 16'd1;
    if (m_pcount >= m_decim || m_pcount == 0) begin
      m_pcount = 0;
      m_ring[m_wpos] = m_ppeak;
      m_ppeak = 0;
      m_wpos = (m_wpos + 1) % RING_LEN;
      if (m_wpos == 0) m_wrapped = 1;
      if (m_wrapped) search_tempo();
      else m_held = '0;
    end
    return m_held;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    mismatch_count++;
  endtask

  // Send one sample beat; predict at acceptance
  task automatic send_sample(logic [15:0] s);
    int gap;
    in_bus.valid <= 1'b1;
    in_bus.audio_sample <= s;
    do @(posedge clk); while (!in_bus.ready);
    pending_estimates.push_back(predict_estimate(s));
    gap = draw_gap();
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Drain all expected beats, then let the block settle
  task automatic wait_drained();
    in_bus.valid <= 1'b0;
    while (pending_estimates.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(atct_pkg::atct_reg_t idx, logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      atct_pkg::REG_LPF_ALPHA: m_alpha = val;
      atct_pkg::REG_DECIM:     m_decim = val;
      atct_pkg::REG_MIN_LAG:   m_min_lag = val[8:0];
      atct_pkg::REG_MAX_LAG:   m_max_lag = val[8:0];
      atct_pkg::REG_CONF_TH:   m_thresh = val;
      default: ;
    endcase
  endtask

  task automatic write_all(logic [15:0] alpha, logic [15:0] decim, logic [15:0] lo,
                           logic [15:0] hi, logic [15:0] th);
    wait_drained();
    write_reg(atct_pkg::REG_LPF_ALPHA, alpha);
    write_reg(atct_pkg::REG_DECIM, decim);
    write_reg(atct_pkg::REG_MIN_LAG, lo);
    write_reg(atct_pkg::REG_MAX_LAG, hi);
    write_reg(atct_pkg::REG_CONF_TH, th);
  endtask

  // Sample source: beat pulses every period envelope steps, noise or extremes
  function automatic logic [15:0] make_sample(int mode, int k, int period);
    int r;
    r = $urandom_range(0, 99);
    if (mode == 0) begin
      if (r < 8) return 16'($urandom);
      if ((k % period) < (period / 3 + 1)) return r[0] ? 16'h8000 : 16'h7FFF - 16'(r);
      return 16'($urandom_range(0, 255));
    end
    if (mode == 1) return 16'($urandom);
    return (r < 30) ? 16'h8000 : (r < 60) ? 16'h7FFF : (r < 80) ? 16'h0000 : 16'hFFFF;
  endfunction

  task automatic run_samples(int count, int mode, int period);
    int k;
    for (k = 0; k < count; k++)
      send_sample(make_sample(mode, k / ((m_decim == 0) ? 1 : int'(m_decim)), period));
  endtask

  // Field extremes at the defaults with no period end, then at decim 1 unwrapped
  task automatic test_reset_extremes();
    logic [15:0] vals [10];
    int i;
    vals = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF, 16'h0001,
             16'h8001, 16'h5555, 16'hAAAA, 16'h7FFF, 16'h8000};
    for (i = 0; i < 10; i++) send_sample(vals[i]);
    write_all(16'hFFFF, 16'd1, 16'd2, 16'd2, 16'd0);
    for (i = 0; i < 10; i++) send_sample(vals[i]);
  endtask

  // Fill the ring at one envelope sample per beat until it wraps, then search
  task automatic test_ring_wrap();
    write_all(16'hFFFF, 16'd1, 16'd395, 16'd399, 16'd307);
    run_samples(430, 0, 7);
  endtask

  // Lag range edges: lower clamp, single lag, empty range, upper clamp, zero decim
  task automatic test_lag_bounds();
    write_all(16'd0, 16'd6, 16'd0, 16'd3, 16'hFFFF);
    run_samples(40, 2, 5);
    write_all(16'd393, 16'd0, 16'd399, 16'd399, 16'd0);
    run_samples(40, 0, 3);
    write_all(16'd20000, 16'd1, 16'd450, 16'd511, 16'd256);
    run_samples(30, 1, 4);
    write_all(16'd50000, 16'd2, 16'd300, 16'd200, 16'd0);
    run_samples(30, 0, 4);
    write_all(16'd8000, 16'd3, 16'd380, 16'd511, 16'd300);
    run_samples(40, 0, 6);
  endtask

  // Searches over the full lag range and over the default range
  task automatic test_wide_search();
    write_all(16'd30000, 16'd400, 16'd0, 16'd511, 16'd200);
    run_samples(420, 0, 9);
    write_all(16'd393, 16'd120, 16'd30, 16'd100, 16'd307);
    run_samples(250, 0, 40);
  endtask

  // Random settings; decimation sized so the search cost stays bounded
  task automatic test_random_phases();
    int p, lo, w, cost, lag, dec;
    for (p = 0; p < 12; p++) begin
      lo = ($urandom_range(0, 5) == 0) ? $urandom_range(2, 100) : $urandom_range(200, 399);
      w = $urandom_range(0, 25);
      cost = 100;
      for (lag = lo; lag <= lo + w && lag <= RING_LEN - 1; lag++) cost += RING_LEN - lag + 56;
      dec = cost / 250 + $urandom_range(1, 3);
      write_all(16'($urandom), 16'(dec), 16'(lo), 16'(lo + w),
                16'($urandom_range(0, 1000)));
      no_idle = (p % 4 == 3);
      run_samples(50, $urandom_range(0, 9) < 7 ? 0 : $urandom_range(1, 2),
                  $urandom_range(2, 30));
      no_idle = 0;
    end
  endtask

  // Output stalls
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_bus.ready <= 1'b0;
    end else if (!no_idle && $urandom_range(0, 7) == 0) begin
      stall_left <= draw_gap();
      out_bus.ready <= 1'b0;
    end else begin
      out_bus.ready <= 1'b1;
    end
  end

  // Compare each output beat with the oldest expected estimate
  always @(posedge clk) begin
    estimate_t want;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (pending_estimates.size() == 0) begin
        report_mismatch("unexpected beat", 1, 0);
      end else begin
        want = pending_estimates.pop_front();
        if (out_bus.beat_lag !== want.beat_lag)
          report_mismatch("beat_lag", out_bus.beat_lag, want.beat_lag);
        if (out_bus.tempo_q4 !== want.tempo_q4)
          report_mismatch("tempo_q4", out_bus.tempo_q4, want.tempo_q4);
        if (out_bus.confidence_q8 !== want.confidence_q8)
          report_mismatch("confidence_q8", out_bus.confidence_q8, want.confidence_q8);
        if (out_bus.tempo_valid !== want.tempo_valid)
          report_mismatch("tempo_valid", out_bus.tempo_valid, want.tempo_valid);
      end
    end
  end

  // Watchdog on cycles without any accepted beat
  always @(posedge clk) begin
    if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  initial begin
    clk = 0;
    rst_n = 0;
    cfg_we = 0;
    cfg_idx = '0;
    cfg_data = '0;
    in_bus.valid = 0;
    in_bus.audio_sample = '0;
    out_bus.ready = 0;
    stall_left = 0;
    no_idle = 0;
    quiet_cycles = 0;
    mismatch_count = 0;
    m_alpha = 16'd393;
    m_decim = 16'd160;
    m_min_lag = 9'd30;
    m_max_lag = 9'd100;
    m_thresh = 16'd307;
    foreach (m_ring[i]) m_ring[i] = '0;
    m_wpos = 0;
    m_wrapped = 0;
    m_level = '0;
    m_pcount = '0;
    m_ppeak = '0;
    m_held = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_extremes();
    test_ring_wrap();
    test_lag_bounds();
    test_wide_search();
    test_random_phases();
    wait_drained();
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/atct_pkg.sv
rtl/atct_in_if.sv
rtl/atct_out_if.sv
rtl/atct_div.sv
rtl/autocorrelation_tempo_tracker_top.sv
tb/autocorrelation_tempo_tracker_top_tb.sv
